// ----- rtl/core/sha_pkg.sv -----
// Package for the SHA-1/SHA-224/SHA-256 hash engine.
// Holds the constants, tables and command type that the controller and datapath share.
// No dependencies.
package sha_pkg;

    localparam logic [1:0] MODE_SHA1   = 2'd0;
    localparam logic [1:0] MODE_SHA224 = 2'd1;
    localparam logic [1:0] MODE_SHA256 = 2'd2;

    // Block word source selects
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_ZERO = 2'd1;
    localparam logic [1:0] SRC_LENH = 2'd2;
    localparam logic [1:0] SRC_LENL = 2'd3;

    typedef struct packed {
        logic       load_iv;     // load chaining value from the initial value
        logic       clr_msg;     // clear byte total
        logic       add_bytes;   // add byte count to total
        logic [3:0] add_cnt;     // up to two words of bytes
        logic       push;        // write one word into the block buffer
        logic [1:0] src;
        logic [31:0] data;
        logic       round_start; // latch working vars from chaining value
        logic       round_step;  // one compression round
        logic [6:0] round_idx;
        logic       round_end;   // fold working vars into chaining value
        logic       sha1;
        logic [2:0] out_idx;
    } sha_cmd_t;

    function automatic logic [31:0] k256(input logic [5:0] i);
        logic [31:0] t [64];
        t = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return t[i];
    endfunction

    function automatic logic [31:0] iv(input logic [1:0] mode, input logic [2:0] i);
        logic [31:0] a [8];
        logic [31:0] b [8];
        logic [31:0] c [8];
        a = '{32'h67452301,32'hefcdab89,32'h98badcfe,32'h10325476,32'hc3d2e1f0,
              32'h0,32'h0,32'h0};
        b = '{32'hc1059ed8,32'h367cd507,32'h3070dd17,32'hf70e5939,32'hffc00b31,
              32'h68581511,32'h64f98fa7,32'hbefa4fa4};
        c = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,32'h510e527f,
              32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        if (mode == MODE_SHA1) return a[i];
        else if (mode == MODE_SHA224) return b[i];
        else return c[i];
    endfunction

endpackage

// ----- rtl/core/sha_datapath.sv -----
// Datapath of the hash engine: block buffer, message schedule, round logic,
// chaining value and byte counter. Depends on sha_pkg; driven by sha_ctrl.
module sha_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        mode,
    input  sha_pkg::sha_cmd_t cmd,
    output logic [31:0]       digest
);

    logic [31:0] w_reg [16];
    logic [31:0] cv_reg [8];
    logic [31:0] v_reg [8];
    logic [63:0] total_reg;
    logic [3:0]  wp_reg;
    logic [31:0] push_word;
    logic [63:0] bits;
    logic [31:0] wnew, wcur, t1, t2, f, k, s0, s1, x15, x2, sx;

    assign bits = {total_reg[60:0], 3'b000};

    always_comb begin
        unique case (cmd.src)
            sha_pkg::SRC_DATA: push_word = cmd.data;
            sha_pkg::SRC_ZERO: push_word = 32'h0;
            sha_pkg::SRC_LENH: push_word = bits[63:32];
            sha_pkg::SRC_LENL: push_word = bits[31:0];
            default:           push_word = 32'h0;
        endcase
    end

    // Message schedule: w_reg is a 16-word window shifted once per round
    always_comb begin
        x15 = w_reg[1];
        x2  = w_reg[14];
        s0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        s1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        sx  = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        if (cmd.sha1) wnew = {sx[30:0], sx[31]};
        else          wnew = w_reg[0] + w_reg[9] + s0 + s1;
        wcur = (cmd.round_idx < 7'd16) ? w_reg[0] : wnew;
    end

    // Round function
    always_comb begin
        f = 32'h0;
        k = 32'h0;
        t1 = 32'h0;
        t2 = 32'h0;
        if (cmd.sha1) begin
            if (cmd.round_idx < 7'd20) begin
                f = (v_reg[1] & v_reg[2]) ^ (~v_reg[1] & v_reg[3]); k = 32'h5a827999;
            end else if (cmd.round_idx < 7'd40) begin
                f = v_reg[1] ^ v_reg[2] ^ v_reg[3]; k = 32'h6ed9eba1;
            end else if (cmd.round_idx < 7'd60) begin
                f = (v_reg[1] & v_reg[2]) ^ (v_reg[1] & v_reg[3]) ^ (v_reg[2] & v_reg[3]);
                k = 32'h8f1bbcdc;
            end else begin
                f = v_reg[1] ^ v_reg[2] ^ v_reg[3]; k = 32'hca62c1d6;
            end
            t1 = {v_reg[0][26:0], v_reg[0][31:27]} + f + v_reg[4] + k + wcur;
        end else begin
            t1 = v_reg[7] + ({v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
                 ^ {v_reg[4][24:0], v_reg[4][31:25]})
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + sha_pkg::k256(cmd.round_idx[5:0]) + wcur;
            t2 = ({v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
                 ^ {v_reg[0][21:0], v_reg[0][31:22]})
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        end
    end

    // Byte counter and buffer write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 64'h0;
            wp_reg    <= 4'h0;
        end else begin
            if (cmd.clr_msg) total_reg <= 64'h0;
            else if (cmd.add_bytes) total_reg <= total_reg + {60'h0, cmd.add_cnt};
            // a word pushed on the clearing cycle takes slot zero
            if (cmd.clr_msg) wp_reg <= cmd.push ? 4'd1 : 4'd0;
            else if (cmd.push) wp_reg <= wp_reg + 4'd1;
        end
    end

    // Block buffer: written by pointer, shifted during rounds
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            w_reg[wp_reg] <= push_word;
        end else if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wcur;
        end
    end

    // Chaining value and working variables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= sha_pkg::iv(sha_pkg::MODE_SHA256, 3'(i));
        end else if (cmd.load_iv) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= sha_pkg::iv(mode, 3'(i));
        end else if (cmd.round_end) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= cv_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= cv_reg[i];
        end else if (cmd.round_step) begin
            if (cmd.sha1) begin
                v_reg[0] <= t1;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= {v_reg[1][1:0], v_reg[1][31:2]};
                v_reg[3] <= v_reg[2];
                v_reg[4] <= v_reg[3];
                for (int i = 5; i < 8; i++) v_reg[i] <= 32'h0;
            end else begin
                v_reg[0] <= t1 + t2;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= v_reg[1];
                v_reg[3] <= v_reg[2];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[5] <= v_reg[4];
                v_reg[6] <= v_reg[5];
                v_reg[7] <= v_reg[6];
            end
        end
    end

    assign digest = cv_reg[cmd.out_idx];

endmodule

// ----- rtl/core/sha_ctrl.sv -----
// Controller of the hash engine: input handshake, padding sequence, round
// counter and digest output. Depends on sha_pkg; commands sha_datapath.
module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        mode,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_word,
    input  logic [2:0]        s_cnt,
    input  logic              s_last,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2:0]        m_idx,
    output logic              m_last,
    output sha_pkg::sha_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        open_reg, open_next;
    logic        fin_reg, fin_next;      // padding in progress
    logic        extra_reg, extra_next;  // 0x80 word still owed (count of four)
    logic        lenw_reg, lenw_next;    // length high word written in this block
    logic [3:0]  wib_reg, wib_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        sha1_reg, sha1_next;
    logic        acc;
    logic [2:0]  cnt_sat;
    logic [31:0] keep, padw;
    logic [2:0]  nwords;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign cnt_sat  = (s_cnt > 3'd4) ? 3'd4 : s_cnt;
    assign nwords   = (mode == sha_pkg::MODE_SHA1) ? 3'd4
                    : (mode == sha_pkg::MODE_SHA224) ? 3'd6 : 3'd7;

    always_comb begin
        unique case (cnt_sat)
            3'd0:    begin keep = 32'h0;        padw = 32'h80000000; end
            3'd1:    begin keep = 32'hff000000; padw = 32'h00800000; end
            3'd2:    begin keep = 32'hffff0000; padw = 32'h00008000; end
            3'd3:    begin keep = 32'hffffff00; padw = 32'h00000080; end
            default: begin keep = 32'hffffffff; padw = 32'h0;        end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        open_next  = open_reg;
        fin_next   = fin_reg;
        extra_next = extra_reg;
        lenw_next  = lenw_reg;
        wib_next   = wib_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        sha1_next  = sha1_reg;
        cmd = '0;
        cmd.src = sha_pkg::SRC_DATA;
        cmd.round_idx = rnd_reg;
        cmd.sha1 = sha1_reg;
        cmd.out_idx = oidx_reg;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    // message start: fresh chaining value
                    if (!open_reg) begin
                        cmd.load_iv = 1'b1;
                        cmd.clr_msg = 1'b1;
                    end
                    open_next = 1'b1;
                    cmd.add_bytes = open_reg;
                    cmd.add_cnt = s_last ? {1'b0, cnt_sat} : 4'd4;
                    cmd.push = 1'b1;
                    cmd.data = s_last ? ((s_word & keep) | padw) : s_word;
                    fin_next = s_last;
                    extra_next = s_last && (cnt_sat == 3'd4);
                    wib_next = open_reg ? wib_reg + 4'd1 : 4'd1;
                    if (!open_reg) begin
                        // byte total cleared this cycle; sha_bytecnt adds this word's bytes
                        extra_next = s_last && (cnt_sat == 3'd4);
                    end
                    if ((open_reg ? wib_reg : 4'd0) == 4'd15) state_next = ST_START;
                    else if (s_last) state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                // 0x80 word first, then zeros; length only if both words fit here
                cmd.push = 1'b1;
                wib_next = wib_reg + 4'd1;
                if (extra_reg) begin
                    cmd.data = 32'h80000000;
                    extra_next = 1'b0;
                end else if (wib_reg == 4'd14) begin
                    cmd.src = sha_pkg::SRC_LENH;
                    lenw_next = 1'b1;
                end else if (wib_reg == 4'd15 && lenw_reg) begin
                    cmd.src = sha_pkg::SRC_LENL;
                end else begin
                    cmd.src = sha_pkg::SRC_ZERO;
                end
                if (wib_reg == 4'd15) state_next = ST_START;
            end
            ST_START: begin
                cmd.round_start = 1'b1;
                sha1_next = (mode == sha_pkg::MODE_SHA1);
                rnd_next = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == (sha1_reg ? 7'd79 : 7'd63)) state_next = ST_END;
            end
            ST_END: begin
                cmd.round_end = 1'b1;
                if (!fin_reg) state_next = ST_IDLE;
                else if (!lenw_reg) state_next = ST_PAD;
                else begin
                    oidx_next = 3'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == nwords) begin
                        state_next = ST_IDLE;
                        open_next = 1'b0;
                        fin_next = 1'b0;
                        lenw_next = 1'b0;
                        cmd.clr_msg = 1'b1;
                        wib_next = 4'd0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_idx  = oidx_reg;
    assign m_last = (oidx_reg == nwords);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
            lenw_reg  <= 1'b0;
            wib_reg   <= 4'd0;
            rnd_reg   <= 7'd0;
            oidx_reg  <= 3'd0;
            sha1_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            fin_reg   <= fin_next;
            extra_reg <= extra_next;
            lenw_reg  <= lenw_next;
            wib_reg   <= wib_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            sha1_reg  <= sha1_next;
        end
    end

endmodule

// ----- rtl/core/sha_bytecnt.sv -----
// Byte count fix-up for the first word of a message: the datapath clears its
// total on that word, so this stage adds that word's bytes in the following cycle.
// Depends on sha_pkg.
module sha_bytecnt (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::sha_cmd_t cmd_in,
    output sha_pkg::sha_cmd_t cmd_out
);

    logic       pend_reg;
    logic [3:0] cnt_reg;

    // Remember the first word's bytes and inject them on the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            pend_reg <= cmd_in.load_iv;
            cnt_reg  <= cmd_in.add_cnt;
        end
    end

    // Merge with the bytes of a word accepted right behind the first one
    always_comb begin
        cmd_out = cmd_in;
        if (pend_reg) begin
            cmd_out.add_bytes = 1'b1;
            cmd_out.add_cnt   = cnt_reg + (cmd_in.add_bytes ? cmd_in.add_cnt : 4'd0);
        end
    end

endmodule

// ----- rtl/core/sha1_sha224_sha256_hash_engine.sv -----
// Top level of the SHA-1/SHA-224/SHA-256 hash engine with APB config port.
// Depends on sha_pkg, sha_ctrl, sha_bytecnt and sha_datapath.
//
//  channel   dir  contents
//  s_axis    in   tdata[31:0] message_word, tdata[34:32] byte_count, tlast last_item
//  m_axis    out  tdata[31:0] digest_word, tdata[34:32] word_index, tlast final_word
//  apb       in   offset 0: hash_mode
//
// A block is loaded word by word, then started, run through 64 (SHA-2) or 80 (SHA-1)
// rounds on the single round unit, and folded back into the chaining value.
// Padding adds up to two blocks after the last word; digest words then leave
// one per cycle under m_tready. Reset (aresetn, synchronous) selects SHA-256.
// s_tready is low while padding runs, a block compresses or the digest drains.
module sha1_sha224_sha256_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // message_word, byte_count, pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // digest_word, word_index, pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]        mode_reg;
    sha_pkg::sha_cmd_t cmd_c, cmd_d;
    logic [31:0]       digest;
    logic [2:0]        idx;

    assign pready = 1'b1;
    assign prdata = paddr ? 32'h0 : {30'h0, mode_reg};

    // Config register write
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= sha_pkg::MODE_SHA256;
        else if (psel && penable && pwrite && !paddr) mode_reg <= pwdata[1:0];
    end

    sha_ctrl u_ctrl (
        .aclk, .aresetn, .mode(mode_reg),
        .s_tvalid, .s_tready, .s_word(s_tdata[31:0]), .s_cnt(s_tdata[34:32]),
        .s_last(s_tlast), .m_tvalid, .m_tready, .m_idx(idx), .m_last(m_tlast),
        .cmd(cmd_c)
    );

    sha_bytecnt u_bytecnt (.aclk, .aresetn, .cmd_in(cmd_c), .cmd_out(cmd_d));

    sha_datapath u_dp (.aclk, .aresetn, .mode(mode_reg), .cmd(cmd_d), .digest);

    assign m_tdata = {5'h0, idx, digest};

endmodule

// ----- tb/sha1_sha224_sha256_hash_engine_tb.sv -----
// Testbench for the SHA-1/SHA-224/SHA-256 hash engine: directed and random messages under
// random stalls, digests checked against a behavioral hash model in a scoreboard.
// Depends on sha_pkg and the engine top level.
`timescale 1ns / 100ps

class digest_scoreboard;
    logic [1:0]  mode;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned nwords;
    logic [63:0] total_bytes;
    bit          open;
    logic [39:0] want_q [$];
    int unsigned errors;

    function void reset_state();
        mode = sha_pkg::MODE_SHA256;
        nwords = 0;
        total_bytes = '0;
        open = 0;
        want_q.delete();
        errors = 0;
    endfunction

    function logic [1:0] algo();
        return (mode >= sha_pkg::MODE_SHA256) ? sha_pkg::MODE_SHA256 : mode;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1, f, k, t, x15, x2;
        w = blk;
        v = chain;
        if (algo() == sha_pkg::MODE_SHA1) begin
            for (int i = 0; i < 80; i++) begin
                if (i >= 16) begin
                    t = w[(i-3)&15] ^ w[(i-8)&15] ^ w[(i-14)&15] ^ w[i&15];
                    w[i&15] = rotr(t, 31);
                end
                if (i < 20) begin
                    f = (v[1] & v[2]) ^ (~v[1] & v[3]); k = 32'h5a827999;
                end else if (i < 40) begin
                    f = v[1] ^ v[2] ^ v[3]; k = 32'h6ed9eba1;
                end else if (i < 60) begin
                    f = (v[1] & v[2]) ^ (v[1] & v[3]) ^ (v[2] & v[3]); k = 32'h8f1bbcdc;
                end else begin
                    f = v[1] ^ v[2] ^ v[3]; k = 32'hca62c1d6;
                end
                t = rotr(v[0], 27) + f + v[4] + k + w[i&15];
                v[4] = v[3]; v[3] = v[2]; v[2] = rotr(v[1], 2); v[1] = v[0]; v[0] = t;
            end
            for (int j = 0; j < 5; j++) chain[j] += v[j];
        end else begin
            for (int i = 0; i < 64; i++) begin
                if (i >= 16) begin
                    x15 = w[(i-15)&15]; x2 = w[(i-2)&15];
                    s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                    s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                    w[i&15] += w[(i-7)&15] + s0 + s1;
                end
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::k256(6'(i)) + w[i&15];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int j = 7; j > 0; j--) v[j] = v[j-1];
                v[4] += t1;
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) chain[j] += v[j];
        end
    endfunction

    function void push_word(logic [31:0] wd);
        blk[nwords] = wd;
        nwords++;
        if (nwords >= 16) begin
            compress();
            nwords = 0;
        end
    endfunction

    // Note one accepted input word; queue the digest when it closes a message
    function void note_word(logic [31:0] wd, logic [2:0] cnt_in, bit last);
        int unsigned cnt, n;
        logic [31:0] keep;
        logic [63:0] bits;
        if (!open) begin
            for (int j = 0; j < 8; j++) chain[j] = sha_pkg::iv(algo(), 3'(j));
            nwords = 0;
            total_bytes = '0;
            open = 1;
        end
        if (!last) begin
            total_bytes += 4;
            push_word(wd);
            return;
        end
        cnt = (cnt_in > 4) ? 4 : cnt_in;
        total_bytes += cnt;
        if (cnt == 4) begin
            push_word(wd);
            push_word(32'h8000_0000);
        end else begin
            keep = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * cnt));
            push_word((wd & keep) | (32'h80 << (24 - 8 * cnt)));
        end
        if (nwords > 14) while (nwords != 0) push_word(32'h0);
        while (nwords < 14) push_word(32'h0);
        bits = total_bytes << 3;
        push_word(bits[63:32]);
        push_word(bits[31:0]);
        n = (algo() == sha_pkg::MODE_SHA1) ? 5 : (algo() == sha_pkg::MODE_SHA224) ? 7 : 8;
        for (int i = 0; i < n; i++)
            want_q.push_back({bit'(i + 1 == n), 4'b0, 3'(i), chain[i]});
        open = 0;
        nwords = 0;
        total_bytes = '0;
    endfunction

    // Check one accepted digest word against the oldest expectation
    function void check_word(logic [39:0] data, logic last);
        logic [39:0] exp;
        if (want_q.size() == 0) begin
            $error("unexpected digest word %h", data[31:0]);
            errors++;
            return;
        end
        exp = want_q.pop_front();
        if (data[31:0] !== exp[31:0]) begin
            $error("digest_word expected %h actual %h", exp[31:0], data[31:0]);
            errors++;
        end
        if (data[34:32] !== exp[34:32]) begin
            $error("word_index expected %0d actual %0d", exp[34:32], data[34:32]);
            errors++;
        end
        if (last !== exp[39]) begin
            $error("final_word expected %0d actual %0d", exp[39], last);
            errors++;
        end
    endfunction
endclass

module sha1_sha224_sha256_hash_engine_tb;

    localparam int LIMIT = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // message_word, byte_count, pad
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;       // digest_word, word_index, pad
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0, paddr = 0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    digest_scoreboard board = new();
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned stall_phase = 0;

    sha1_sha224_sha256_hash_engine dut (.*);

    always #1 aclk = ~aclk;

    // Check digest words at the rising edge; abort on the cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stall pattern: long ready runs alternating with random stalls
    always @(negedge aclk) begin
        stall_phase++;
        if (stall_phase[8]) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_mode(logic [1:0] m);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {30'b0, m}; penable <= 0;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.mode = m;
    endtask

    // Send one word, inserting burst gaps before it, and wait for acceptance
    task automatic send_word(logic [31:0] wd, logic [2:0] cnt, bit last);
        if (burst_left == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= {5'b0, cnt, wd};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_word(wd, cnt, last);
        @(negedge aclk);
    endtask

    task automatic send_message(int unsigned nfull, logic [2:0] cnt);
        for (int i = 0; i < nfull; i++) send_word($urandom, 3'($urandom_range(0, 7)), 0);
        send_word($urandom, cnt, 1);
    endtask

    // Drop valid and wait until every digest word has drained
    task automatic drain();
        s_tvalid <= 0;
        s_tlast <= 0;
        @(negedge aclk);
        while (board.want_q.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    initial begin
        logic [1:0] modes [4] = '{sha_pkg::MODE_SHA256, sha_pkg::MODE_SHA1,
                                  sha_pkg::MODE_SHA224, 2'd3};
        board.reset_state();
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: empty, extreme words, every byte count, block boundaries
        for (int m = 0; m < 4; m++) begin
            write_mode(modes[m]);
            send_word(32'h0, 3'd0, 1);
            send_word(32'hffff_ffff, 3'd7, 1);
            send_word(32'hffff_ffff, 3'd3, 1);
            send_message(13, 3'd1);
            send_message(14, 3'd2);
            send_message(15, 3'd4);
            drain();
        end

        // Mode change mid-message: first block under one mode, digest under another
        write_mode(sha_pkg::MODE_SHA1);
        for (int i = 0; i < 16; i++) send_word($urandom, 3'd0, 0);
        drain();
        write_mode(sha_pkg::MODE_SHA256);
        send_word(32'h1234_5678, 3'd2, 1);
        drain();

        // Random messages, mostly short, across all modes
        for (int r = 0; r < 5; r++) begin
            write_mode(modes[$urandom_range(0, 3)]);
            for (int k = 0; k < 5; k++)
                send_message(($urandom_range(0, 5) == 0) ? $urandom_range(16, 34)
                             : $urandom_range(0, 12), 3'($urandom_range(0, 7)));
            drain();
        end
        write_mode(sha_pkg::MODE_SHA256);

        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
